>>> rtl/aacdf_pkg.sv
package aacdf_pkg;

    localparam int unsigned TS_W       = 33;
    localparam int unsigned TS_OUT_W   = 32;
    localparam int unsigned LEN_W      = 13;

    localparam logic [7:0]       SYNC_BYTE      = 8'hFF;
    localparam logic [7:0]       SYNC_NIBBLE    = 8'hF0;
    localparam logic [7:0]       ID_MASK        = 8'b0000_1000;
    localparam logic [7:0]       LAYER_MASK     = 8'b0000_0110;
    localparam logic [3:0]       RATE_MAX       = 4'd12;
    localparam logic [1:0]       PROFILE_OTHER  = 2'd2;
    localparam logic [2:0]       CH_MONO        = 3'd1;
    localparam logic [2:0]       CH_STEREO      = 3'd2;
    localparam logic [LEN_W-1:0] HDR_LEN_PLAIN  = 13'd7;
    localparam logic [LEN_W-1:0] HDR_LEN_CRC    = 13'd9;

    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_SYNC     = 4'd1,
        ERR_MPEG2    = 4'd2,
        ERR_LAYER    = 4'd3,
        ERR_RATE     = 4'd4,
        ERR_CHANNELS = 4'd5,
        ERR_BLOCKS   = 4'd6,
        ERR_SHORT    = 4'd7,
        ERR_MISMATCH = 4'd8,
        ERR_SPANS    = 4'd9
    } t_err;

    typedef struct packed {
        logic [7:0]          payload_byte;
        logic                frame_first;
        logic                frame_last;
        logic [TS_OUT_W-1:0] frame_pts;
        logic [TS_OUT_W-1:0] frame_dts;
        logic [1:0]          profile_code;
        logic [3:0]          rate_index;
        logic [1:0]          channel_count;
        t_err                error_code;
    } t_result;

endpackage

>>> rtl/aacdf_parser.sv
module aacdf_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_packet_start,
    input  logic [aacdf_pkg::TS_W-1:0]     i_pes_pts,
    input  logic [aacdf_pkg::TS_W-1:0]     i_pes_dts,
    output logic                           o_res_valid,
    output aacdf_pkg::t_result             o_res
);

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_PAY  = 2'd1,
        PH_SKIP = 2'd2
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [3:0]                          r_header_count, n_header_count;
    logic                                r_crc_present, n_crc_present;
    logic [aacdf_pkg::LEN_W-1:0]         r_frame_length, n_frame_length;
    logic [aacdf_pkg::LEN_W-1:0]         r_bytes_left, n_bytes_left;
    logic [1:0]                          r_cur_profile, n_cur_profile;
    logic [3:0]                          r_cur_rate, n_cur_rate;
    logic [2:0]                          r_cur_channels, n_cur_channels;
    logic                                r_first_seen, n_first_seen;
    logic [1:0]                          r_first_profile, n_first_profile;
    logic [3:0]                          r_first_rate, n_first_rate;
    logic [1:0]                          r_first_channels, n_first_channels;
    logic [aacdf_pkg::TS_OUT_W-1:0]      r_latched_pts, n_latched_pts;
    logic [aacdf_pkg::TS_OUT_W-1:0]      r_latched_dts, n_latched_dts;
    logic [aacdf_pkg::TS_OUT_W-1:0]      r_hdr_pts, n_hdr_pts;
    logic [aacdf_pkg::TS_OUT_W-1:0]      r_hdr_dts, n_hdr_dts;
    logic [1:0]                          r_crossed, n_crossed;

    logic [aacdf_pkg::LEN_W-1:0]         w_hdr_len;
    logic [aacdf_pkg::LEN_W-1:0]         w_pay_len;
    logic [2:0]                          w_ch;
    logic                                w_fail;
    aacdf_pkg::t_err                     w_code;

    assign w_hdr_len = r_crc_present ? aacdf_pkg::HDR_LEN_CRC : aacdf_pkg::HDR_LEN_PLAIN;
    assign w_pay_len = r_frame_length - w_hdr_len;
    assign w_ch      = r_cur_channels | {1'b0, i_data_byte[7:6]};

    always_comb begin
        n_phase          = r_phase;
        n_header_count   = r_header_count;
        n_crc_present    = r_crc_present;
        n_frame_length   = r_frame_length;
        n_bytes_left     = r_bytes_left;
        n_cur_profile    = r_cur_profile;
        n_cur_rate       = r_cur_rate;
        n_cur_channels   = r_cur_channels;
        n_first_seen     = r_first_seen;
        n_first_profile  = r_first_profile;
        n_first_rate     = r_first_rate;
        n_first_channels = r_first_channels;
        n_latched_pts    = r_latched_pts;
        n_latched_dts    = r_latched_dts;
        n_hdr_pts        = r_hdr_pts;
        n_hdr_dts        = r_hdr_dts;
        n_crossed        = r_crossed;
        w_fail           = 1'b0;
        w_code           = aacdf_pkg::ERR_OK;
        o_res_valid      = 1'b0;
        o_res            = '0;

        if (i_step) begin
            if (i_packet_start) begin
                n_latched_pts = i_pes_pts[aacdf_pkg::TS_OUT_W-1:0];
                n_latched_dts = i_pes_dts[aacdf_pkg::TS_OUT_W-1:0];
                if (r_phase == PH_SKIP) begin
                    n_phase        = PH_HEAD;
                    n_header_count = 4'd0;
                end else if (r_phase == PH_PAY || r_header_count != 4'd0) begin
                    n_crossed = r_crossed + 2'd1;
                    // a frame may straddle one packet boundary, not two
                    if (n_crossed >= 2'd2) begin
                        w_fail = 1'b1;
                        w_code = aacdf_pkg::ERR_SPANS;
                    end
                end
            end

            if (!w_fail && n_phase == PH_PAY) begin
                o_res_valid          = 1'b1;
                o_res.payload_byte   = i_data_byte;
                o_res.frame_first    = (r_frame_length >= w_hdr_len) &&
                                       (r_bytes_left == w_pay_len);
                o_res.frame_last     = (r_bytes_left <= 13'd1);
                o_res.frame_pts      = r_hdr_pts;
                o_res.frame_dts      = r_hdr_dts;
                o_res.profile_code   = r_cur_profile;
                o_res.rate_index     = r_cur_rate;
                o_res.channel_count  = r_cur_channels[1:0];
                o_res.error_code     = aacdf_pkg::ERR_OK;
                if (r_bytes_left <= 13'd1) begin
                    n_bytes_left   = '0;
                    n_phase        = PH_HEAD;
                    n_header_count = 4'd0;
                    n_crossed      = 2'd0;
                end else begin
                    n_bytes_left = r_bytes_left - 13'd1;
                end
            end else if (!w_fail && n_phase == PH_HEAD) begin
                case (n_header_count)
                    4'd0: begin
                        if (i_data_byte != aacdf_pkg::SYNC_BYTE) begin
                            w_fail = 1'b1;
                            w_code = aacdf_pkg::ERR_SYNC;
                        end else begin
                            n_hdr_pts = n_latched_pts;
                            n_hdr_dts = n_latched_dts;
                            n_crossed = 2'd0;
                        end
                    end
                    4'd1: begin
                        if ((i_data_byte & aacdf_pkg::SYNC_NIBBLE) != aacdf_pkg::SYNC_NIBBLE) begin
                            w_fail = 1'b1;
                            w_code = aacdf_pkg::ERR_SYNC;
                        end else if ((i_data_byte & aacdf_pkg::ID_MASK) != 8'd0) begin
                            w_fail = 1'b1;
                            w_code = aacdf_pkg::ERR_MPEG2;
                        end else if ((i_data_byte & aacdf_pkg::LAYER_MASK) != 8'd0) begin
                            w_fail = 1'b1;
                            w_code = aacdf_pkg::ERR_LAYER;
                        end else begin
                            n_crc_present = ~i_data_byte[0];
                        end
                    end
                    4'd2: begin
                        n_cur_profile  = (i_data_byte[7:6] < aacdf_pkg::PROFILE_OTHER) ?
                                         i_data_byte[7:6] : aacdf_pkg::PROFILE_OTHER;
                        n_cur_rate     = i_data_byte[5:2];
                        n_cur_channels = {i_data_byte[0], 2'b00};
                        if (i_data_byte[5:2] > aacdf_pkg::RATE_MAX) begin
                            w_fail = 1'b1;
                            w_code = aacdf_pkg::ERR_RATE;
                        end
                    end
                    4'd3: begin
                        if (w_ch != aacdf_pkg::CH_MONO && w_ch != aacdf_pkg::CH_STEREO) begin
                            w_fail = 1'b1;
                            w_code = aacdf_pkg::ERR_CHANNELS;
                        end else begin
                            n_cur_channels = w_ch;
                            n_frame_length = {i_data_byte[1:0], 11'd0};
                        end
                    end
                    4'd4: begin
                        n_frame_length = r_frame_length | {2'b00, i_data_byte, 3'b000};
                    end
                    4'd5: begin
                        n_frame_length = r_frame_length | {10'd0, i_data_byte[7:5]};
                    end
                    4'd6: begin
                        if (i_data_byte[1:0] != 2'b00) begin
                            w_fail = 1'b1;
                            w_code = aacdf_pkg::ERR_BLOCKS;
                        end else if (r_frame_length <= w_hdr_len) begin
                            w_fail = 1'b1;
                            w_code = aacdf_pkg::ERR_SHORT;
                        end else if (r_first_seen &&
                                     (r_cur_profile != r_first_profile ||
                                      r_cur_rate != r_first_rate ||
                                      r_cur_channels != {1'b0, r_first_channels})) begin
                            w_fail = 1'b1;
                            w_code = aacdf_pkg::ERR_MISMATCH;
                        end else begin
                            if (!r_first_seen) begin
                                n_first_profile  = r_cur_profile;
                                n_first_rate     = r_cur_rate;
                                n_first_channels = r_cur_channels[1:0];
                                n_first_seen     = 1'b1;
                            end
                            n_bytes_left = w_pay_len;
                        end
                    end
                    4'd7: begin
                        // first CRC byte: nothing to keep
                    end
                    default: begin
                    end
                endcase

                if (!w_fail) begin
                    if ((n_header_count == 4'd6 && !r_crc_present) ||
                        n_header_count >= 4'd8) begin
                        n_phase        = PH_PAY;
                        n_header_count = 4'd0;
                    end else begin
                        n_header_count = n_header_count + 4'd1;
                    end
                end
            end

            if (w_fail) begin
                n_phase          = PH_SKIP;
                n_header_count   = 4'd0;
                n_crossed        = 2'd0;
                o_res_valid      = 1'b1;
                o_res            = '0;
                o_res.error_code = w_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HEAD;
            r_header_count   <= '0;
            r_crc_present    <= 1'b0;
            r_frame_length   <= '0;
            r_bytes_left     <= '0;
            r_cur_profile    <= '0;
            r_cur_rate       <= '0;
            r_cur_channels   <= '0;
            r_first_seen     <= 1'b0;
            r_first_profile  <= '0;
            r_first_rate     <= '0;
            r_first_channels <= '0;
            r_latched_pts    <= '0;
            r_latched_dts    <= '0;
            r_hdr_pts        <= '0;
            r_hdr_dts        <= '0;
            r_crossed        <= '0;
        end else begin
            r_phase          <= n_phase;
            r_header_count   <= n_header_count;
            r_crc_present    <= n_crc_present;
            r_frame_length   <= n_frame_length;
            r_bytes_left     <= n_bytes_left;
            r_cur_profile    <= n_cur_profile;
            r_cur_rate       <= n_cur_rate;
            r_cur_channels   <= n_cur_channels;
            r_first_seen     <= n_first_seen;
            r_first_profile  <= n_first_profile;
            r_first_rate     <= n_first_rate;
            r_first_channels <= n_first_channels;
            r_latched_pts    <= n_latched_pts;
            r_latched_dts    <= n_latched_dts;
            r_hdr_pts        <= n_hdr_pts;
            r_hdr_dts        <= n_hdr_dts;
            r_crossed        <= n_crossed;
        end
    end

    a_err_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.error_code != aacdf_pkg::ERR_OK)
        |=> (r_phase == PH_SKIP))
        else $error("error result not followed by skip");

    a_pay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_bytes_left != '0))
        else $error("payload phase with no bytes left");

    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_header_count <= 4'd8))
        else $error("header count ran past CRC bytes");

    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_SKIP && !i_packet_start) |-> !o_res_valid)
        else $error("result produced while skipping");

endmodule

>>> rtl/adts_aac_frame_deframer_top.sv
// ADTS AAC deframer.
// Slave stream: one elementary-stream byte per item. tdata carries the byte,
// the packet pts and the packet dts; tuser flags the first byte of a PES packet.
// Master stream: one result item per payload byte, or one error item when a
// header check fails or a frame crosses a second packet boundary; header bytes
// and skipped bytes produce nothing. tlast marks the last payload byte of a
// frame, tuser carries the first-byte mark and the error code (zero when ok).
// Output: a result is registered and presented in the cycle after its byte is taken.
// Throughput: one byte per cycle while the output is not stalled; all parsing for a
// byte is combinational, between the input handshake and the output register.
// Reset (i_rst_n low, synchronous): the output register empties and the parser
// waits for a sync byte with zero timestamps and no first-frame settings.
// Stall: while a result waits with m_axis_tready low, s_axis_tready drops and
// the held item stays on the master side unchanged.
module adts_aac_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [40:8] pes_pts, [73:41] pes_dts, [79:74] zero
    input  logic [79:0] s_axis_tdata,
    // [0] packet_start
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [39:8] frame_pts, [71:40] frame_dts,
    // [73:72] profile_code, [77:74] rate_index, [79:78] channel_count
    output logic [79:0] m_axis_tdata,
    // [0] frame_first, [4:1] error_code
    output logic [4:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic                 w_accept;
    logic                 w_res_valid;
    aacdf_pkg::t_result   w_res;
    logic                 r_out_valid;
    aacdf_pkg::t_result   r_out;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    aacdf_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_accept),
        .i_data_byte    (s_axis_tdata[7:0]),
        .i_packet_start (s_axis_tuser[0]),
        .i_pes_pts      (s_axis_tdata[40:8]),
        .i_pes_dts      (s_axis_tdata[73:41]),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= w_accept && w_res_valid;
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.frame_last;
    assign m_axis_tuser  = {r_out.error_code, r_out.frame_first};
    assign m_axis_tdata  = {r_out.channel_count, r_out.rate_index, r_out.profile_code,
                            r_out.frame_dts, r_out.frame_pts, r_out.payload_byte};

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[4:1] != aacdf_pkg::ERR_OK)
        |-> (m_axis_tdata == '0 && !m_axis_tlast && !m_axis_tuser[0]))
        else $error("error item carries payload fields");

    a_ok_channels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[4:1] == aacdf_pkg::ERR_OK)
        |-> (m_axis_tdata[79:78] == 2'd1 || m_axis_tdata[79:78] == 2'd2))
        else $error("payload item with bad channel count");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result is stalled");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef enum logic [1:0] {
        SCAN_HEADER  = 2'd0,
        SCAN_PAYLOAD = 2'd1,
        SCAN_SKIP    = 2'd2
    } t_scan;

    typedef struct packed {
        logic [7:0]  b;
        logic        ps;
        logic [32:0] pts;
        logic [32:0] dts;
    } t_es_byte;

    localparam int HOLD_CYCLES = 200;
    localparam logic [3:0] RMAX   = aacdf_pkg::RATE_MAX;
    localparam logic [2:0] STEREO = aacdf_pkg::CH_STEREO;
    localparam logic [2:0] MONO   = aacdf_pkg::CH_MONO;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;

    adts_aac_frame_deframer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // parser copy
    t_scan       scan = SCAN_HEADER;
    logic [3:0]  hdr_cnt = '0;
    logic        crc_on = 1'b0;
    logic [12:0] frame_len = '0;
    logic [12:0] bytes_left = '0;
    logic [1:0]  cur_profile = '0;
    logic [3:0]  cur_rate = '0;
    logic [2:0]  cur_ch = '0;
    logic        first_seen = 1'b0;
    logic [1:0]  first_profile = '0;
    logic [3:0]  first_rate = '0;
    logic [1:0]  first_ch = '0;
    logic [32:0] pkt_pts = '0;
    logic [32:0] pkt_dts = '0;
    logic [31:0] hdr_pts = '0;
    logic [31:0] hdr_dts = '0;
    logic [1:0]  crossings = '0;
    int          sent_count = 0;

    aacdf_pkg::t_result frame_bytes_due [$];
    t_es_byte           es_stream [$];

    int   fail_count = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    aacdf_pkg::t_result want;

    function automatic void raise_error(input aacdf_pkg::t_err code);
        aacdf_pkg::t_result r;
        r = '0;
        r.error_code = code;
        frame_bytes_due.insert(frame_bytes_due.size(), r);
        scan = SCAN_SKIP;
        hdr_cnt = '0;
        crossings = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic ps,
                                       input logic [32:0] pts, input logic [32:0] dts);
        aacdf_pkg::t_result r;
        logic [12:0] hlen;
        logic [2:0] ch;
        r = '0;
        if (ps) begin
            pkt_pts = pts;
            pkt_dts = dts;
            if (scan == SCAN_SKIP) begin
                scan = SCAN_HEADER;
                hdr_cnt = '0;
            end else if (scan == SCAN_PAYLOAD || hdr_cnt != 0) begin
                crossings = crossings + 2'd1;
                if (crossings >= 2) begin
                    raise_error(aacdf_pkg::ERR_SPANS);
                    return;
                end
            end
        end
        if (scan == SCAN_SKIP) return;
        hlen = crc_on ? aacdf_pkg::HDR_LEN_CRC : aacdf_pkg::HDR_LEN_PLAIN;

        if (scan == SCAN_PAYLOAD) begin
            r.payload_byte  = b;
            r.frame_first   = (frame_len >= hlen) && (bytes_left == frame_len - hlen);
            r.frame_last    = (bytes_left <= 1);
            r.frame_pts     = hdr_pts;
            r.frame_dts     = hdr_dts;
            r.profile_code  = cur_profile;
            r.rate_index    = cur_rate;
            r.channel_count = cur_ch[1:0];
            r.error_code    = aacdf_pkg::ERR_OK;
            frame_bytes_due.insert(frame_bytes_due.size(), r);
            if (bytes_left <= 1) begin
                bytes_left = '0;
                scan = SCAN_HEADER;
                hdr_cnt = '0;
                crossings = '0;
            end else begin
                bytes_left = bytes_left - 13'd1;
            end
            return;
        end

        case (hdr_cnt)
            4'd0: begin
                if (b != aacdf_pkg::SYNC_BYTE) begin
                    raise_error(aacdf_pkg::ERR_SYNC);
                    return;
                end
                hdr_pts = pkt_pts[31:0];
                hdr_dts = pkt_dts[31:0];
                crossings = '0;
            end
            4'd1: begin
                if ((b & aacdf_pkg::SYNC_NIBBLE) != aacdf_pkg::SYNC_NIBBLE) begin
                    raise_error(aacdf_pkg::ERR_SYNC);
                    return;
                end
                if ((b & aacdf_pkg::ID_MASK) != 0) begin
                    raise_error(aacdf_pkg::ERR_MPEG2);
                    return;
                end
                if ((b & aacdf_pkg::LAYER_MASK) != 0) begin
                    raise_error(aacdf_pkg::ERR_LAYER);
                    return;
                end
                crc_on = ~b[0];
            end
            4'd2: begin
                cur_profile = (b[7:6] < aacdf_pkg::PROFILE_OTHER) ?
                              b[7:6] : aacdf_pkg::PROFILE_OTHER;
                cur_rate = b[5:2];
                if (cur_rate > RMAX) begin
                    raise_error(aacdf_pkg::ERR_RATE);
                    return;
                end
                cur_ch = {b[0], 2'b00};
            end
            4'd3: begin
                ch = cur_ch | {1'b0, b[7:6]};
                if (ch != MONO && ch != STEREO) begin
                    raise_error(aacdf_pkg::ERR_CHANNELS);
                    return;
                end
                cur_ch = ch;
                frame_len = {b[1:0], 11'd0};
            end
            4'd4: frame_len = frame_len | {2'b00, b, 3'b000};
            4'd5: frame_len = frame_len | {10'd0, b[7:5]};
            4'd6: begin
                if (b[1:0] != 2'b00) begin
                    raise_error(aacdf_pkg::ERR_BLOCKS);
                    return;
                end
                if (frame_len <= hlen) begin
                    raise_error(aacdf_pkg::ERR_SHORT);
                    return;
                end
                if (first_seen) begin
                    if (cur_profile != first_profile || cur_rate != first_rate ||
                        cur_ch != {1'b0, first_ch}) begin
                        raise_error(aacdf_pkg::ERR_MISMATCH);
                        return;
                    end
                end else begin
                    first_profile = cur_profile;
                    first_rate = cur_rate;
                    first_ch = cur_ch[1:0];
                    first_seen = 1'b1;
                end
                bytes_left = frame_len - hlen;
                if (!crc_on) begin
                    scan = SCAN_PAYLOAD;
                    hdr_cnt = '0;
                    return;
                end
            end
            4'd7: ;
            default: begin
                scan = SCAN_PAYLOAD;
                hdr_cnt = '0;
                return;
            end
        endcase
        hdr_cnt = hdr_cnt + 4'd1;
    endfunction

    function automatic logic [32:0] rand_ts();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {hi[0], lo};
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic ps);
        t_es_byte it;
        it.b = b;
        it.ps = ps;
        it.pts = rand_ts();
        it.dts = rand_ts();
        es_stream.insert(es_stream.size(), it);
    endfunction

    // splits: packet starts inside the frame; cut: truncate after that many bytes
    function automatic void add_frame(input logic [1:0] prof, input logic [3:0] rate,
            input logic [2:0] chans, input logic crc, input logic [12:0] flen,
            input logic [1:0] blocks, input logic id_bit, input logic [1:0] layer,
            input logic ps_first, input int splits, input int cut);
        logic [7:0] hb [0:8];
        logic [31:0] r;
        logic [31:0] r2;
        logic [7:0] b;
        int hlen, total, p1, p2, i;
        r = $urandom;
        r2 = $urandom;
        hlen = int'(crc ? aacdf_pkg::HDR_LEN_CRC : aacdf_pkg::HDR_LEN_PLAIN);
        hb[0] = aacdf_pkg::SYNC_BYTE;
        hb[1] = aacdf_pkg::SYNC_NIBBLE | {4'h0, id_bit, layer, ~crc};
        hb[2] = {prof, rate, r[0], chans[2]};
        hb[3] = {chans[1:0], r[4:1], flen[12:11]};
        hb[4] = flen[10:3];
        hb[5] = {flen[2:0], r[31:27]};
        hb[6] = {r[26:21], blocks};
        hb[7] = r2[7:0];
        hb[8] = r2[15:8];
        total = (int'(flen) > hlen) ? int'(flen) : hlen;
        if (cut > 0 && cut < total) total = cut;
        p1 = -1;
        p2 = -1;
        if (splits == 1) begin
            p1 = int'($urandom_range(total - 1, 1));
        end else if (splits >= 2) begin
            p1 = int'($urandom_range(total / 2, 1));
            p2 = int'($urandom_range(total - 1, total / 2 + 1));
        end
        for (i = 0; i < total; i++) begin
            b = 8'($urandom);
            if (i < hlen) b = hb[i];
            add_byte(b, (i == 0 && ps_first) || i == p1 || i == p2);
        end
    endfunction

    function automatic void add_good(input logic crc, input int plen, input logic ps_first,
                                     input int splits);
        logic [12:0] flen;
        logic [31:0] r;
        r = $urandom;
        flen = 13'((crc ? aacdf_pkg::HDR_LEN_CRC : aacdf_pkg::HDR_LEN_PLAIN) + plen);
        add_frame({1'b1, r[0]}, RMAX, STEREO, crc, flen, 2'b00, 1'b0, 2'b00,
                  ps_first, splits, 0);
    endfunction

    // one defect per frame: a bad header field, a truncation or two packet boundaries
    function automatic void add_broken(input logic crc, input logic [12:0] flen,
                                       input logic ps_first);
        logic [1:0] prof;
        logic [3:0] rate;
        logic [2:0] chans;
        logic [1:0] blocks;
        logic [1:0] layer;
        logic [31:0] r;
        logic id_bit;
        logic [12:0] blen;
        int splits, cut, hlen;
        r = $urandom;
        blen = flen;
        hlen = int'(crc ? aacdf_pkg::HDR_LEN_CRC : aacdf_pkg::HDR_LEN_PLAIN);
        prof = {1'b1, r[8]};
        rate = RMAX;
        chans = STEREO;
        blocks = 2'b00;
        layer = 2'b00;
        id_bit = 1'b0;
        splits = 0;
        cut = 0;
        case ($urandom_range(8))
            0: id_bit = 1'b1;
            1: layer = 2'($urandom_range(3, 1));
            2: rate = 4'($urandom_range(15, 13));
            3: chans = r[0] ? 3'd0 : 3'($urandom_range(7, 3));
            4: blocks = 2'($urandom_range(3, 1));
            5: blen = 13'($urandom_range(hlen, 0));
            6: begin
                case (r[2:1])
                    2'd0: prof = {1'b0, r[0]};
                    2'd1: rate = 4'($urandom_range(11, 0));
                    2'd2: chans = MONO;
                    default: begin
                        prof = {1'b0, r[0]};
                        chans = MONO;
                    end
                endcase
            end
            7: cut = int'($urandom_range(hlen + 2, 1));
            default: splits = 2;
        endcase
        add_frame(prof, rate, chans, crc, blen, blocks, id_bit, layer, ps_first, splits, cut);
    endfunction

    function automatic void add_noise(input int n);
        logic [31:0] r;
        logic [7:0] b;
        int i;
        for (i = 0; i < n; i++) begin
            r = $urandom;
            b = r[7:0];
            if (i == 0 && r[8]) b = aacdf_pkg::SYNC_BYTE;
            add_byte(b, r[11:10] == 2'b00);
        end
    endfunction

    task automatic send_item(input t_es_byte it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, it.dts, it.pts, it.b};
        s_axis_tuser  <= it.ps;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        sent_count++;
        parse_byte(it.b, it.ps, it.pts, it.dts);
    endtask

    task automatic send_stream();
        while (es_stream.size() != 0) send_item(es_stream.pop_front());
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_first_frame();
        // no packet start yet: the frame carries zero timestamps
        add_frame(2'b11, RMAX, STEREO, 1'b0, 13'd11, 2'b00, 1'b0, 2'b00, 1'b0, 0, 0);
        add_frame(2'b10, RMAX, STEREO, 1'b1, 13'd10, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, STEREO, 1'b0, 13'd8, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        send_stream();
    endtask

    task automatic test_header_checks();
        add_byte(8'hFE, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(aacdf_pkg::SYNC_BYTE, 1'b1);
        add_byte(8'h71, 1'b0);
        add_frame(2'b11, RMAX, STEREO, 1'b0, 13'd12, 2'b00, 1'b1, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, STEREO, 1'b0, 13'd12, 2'b00, 1'b0, 2'b01, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, STEREO, 1'b1, 13'd12, 2'b00, 1'b0, 2'b10, 1'b1, 0, 0);
        add_frame(2'b11, 4'd13, STEREO, 1'b0, 13'd12, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, 4'd15, STEREO, 1'b0, 13'd12, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, 3'd0, 1'b0, 13'd12, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, 3'd3, 1'b0, 13'd12, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, 3'd6, 1'b0, 13'd12, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, STEREO, 1'b0, 13'd12, 2'b01, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, STEREO, 1'b1, 13'd12, 2'b11, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, STEREO, 1'b0, 13'd7, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, STEREO, 1'b1, 13'd9, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, STEREO, 1'b0, 13'd0, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b00, RMAX, STEREO, 1'b0, 13'd12, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b01, RMAX, STEREO, 1'b0, 13'd12, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, 4'd0, STEREO, 1'b0, 13'd12, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        add_frame(2'b11, RMAX, MONO, 1'b0, 13'd12, 2'b00, 1'b0, 2'b00, 1'b1, 0, 0);
        // resume on the next packet start
        add_good(1'b0, 3, 1'b1, 0);
        send_stream();
    endtask

    task automatic test_boundaries();
        add_good(1'b0, 20, 1'b1, 1);
        // longest frame length, cut short by a second boundary in the payload
        add_frame(2'b11, RMAX, STEREO, 1'b0, 13'h1FFF, 2'b00, 1'b0, 2'b00, 1'b1, 2, 40);
        add_frame(2'b10, RMAX, STEREO, 1'b1, 13'd30, 2'b00, 1'b0, 2'b00, 1'b1, 2, 8);
        add_good(1'b1, 5, 1'b1, 0);
        send_stream();
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        add_good(1'b0, 60, 1'b1, 0);
        add_good(1'b1, 30, 1'b1, 0);
        send_stream();
        wait_drain();
    endtask

    task automatic run_random(input int target);
        int goal, k, splits;
        logic [31:0] r;
        logic crc;
        logic ps_first;
        logic [12:0] hlen;
        logic [12:0] plen;
        goal = sent_count + target;
        while (sent_count < goal) begin
            r = $urandom;
            k = int'($urandom_range(99));
            crc = r[0];
            hlen = crc ? aacdf_pkg::HDR_LEN_CRC : aacdf_pkg::HDR_LEN_PLAIN;
            plen = (r[7:4] == 4'd0) ? 13'($urandom_range(300, 25)) :
                                      13'($urandom_range(24, 1));
            splits = (r[15:11] == 5'd0) ? 2 : (r[15:13] == 3'd0) ? 1 : 0;
            ps_first = (scan == SCAN_SKIP) || r[16] || r[17];
            if (k < 80)
                add_good(crc, int'(plen), ps_first, splits);
            else if (k < 94)
                add_broken(crc, hlen + plen, ps_first);
            else
                add_noise(int'($urandom_range(12, 1)));
            send_stream();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (frame_bytes_due.size() == 0) begin
                $error("result item with none expected: tdata %0h tuser %0h",
                       m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = frame_bytes_due.pop_front();
                check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
                check_field("frame_first", want.frame_first, m_axis_tuser[0]);
                check_field("frame_last", want.frame_last, m_axis_tlast);
                check_field("frame_pts", want.frame_pts, m_axis_tdata[39:8]);
                check_field("frame_dts", want.frame_dts, m_axis_tdata[71:40]);
                check_field("profile_code", want.profile_code, m_axis_tdata[73:72]);
                check_field("rate_index", want.rate_index, m_axis_tdata[77:74]);
                check_field("channel_count", want.channel_count, m_axis_tdata[79:78]);
                check_field("error_code", want.error_code, m_axis_tuser[4:1]);
            end
        end
    end

    initial begin
        #1000000;
        $display("adts_aac_frame_deframer_top verification failed");
        $finish;
    end

    initial begin
        tx_idle_pct = 34;
        rx_idle_pct = 80;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_frame();
        test_header_checks();
        test_boundaries();
        run_random(240);
        wait_drain();

        tx_idle_pct = 80;
        rx_idle_pct = 34;
        run_random(240);
        wait_drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        run_random(240);
        wait_drain();

        if (fail_count == 0)
            $display("adts_aac_frame_deframer_top verification clean");
        else
            $display("adts_aac_frame_deframer_top verification failed");
        $finish;
    end

endmodule
